// ----- rtl/core/u8dec_pkg.sv -----
// u8dec_pkg: shared types and helpers for the utf-8 to ucs-2 decoder
// used by every module under rtl/core; depends on nothing
`timescale 1ns / 1ps

package u8dec_pkg;

  // unit queue depth, counted in groups
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  // most code units one byte can release
  localparam int unsigned MaxUnits = 3;

  // byte classes and masks
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContCode  = 8'h80;
  localparam logic [2:0] Lead3Code = 3'b111;
  localparam logic [2:0] Lead2Code = 3'b110;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        string_done;
  } out_item_t;

  // units released by one byte, oldest in slot 0
  typedef struct packed {
    logic [MaxUnits-1:0][15:0] units;
    logic [1:0]                cnt;
    logic                      done;
  } group_t;

  function automatic logic is_cont(input logic [7:0] b);
    return (b & ContMask) == ContCode;
  endfunction

endpackage

// ----- rtl/core/u8dec_front.sv -----
// u8dec_front: takes bytes, keeps the undecided ones and resolves each
// byte into a group of up to three code units; uses u8dec_pkg
`timescale 1ns / 1ps

module u8dec_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  u8dec_pkg::in_item_t in_item_i,
  input  logic                q_full_i,
  output logic                push_o,
  output u8dec_pkg::group_t   group_o
);
  import u8dec_pkg::*;

  logic [1:0][7:0] pend_q, pend_d;
  logic [1:0]      pend_cnt_q, pend_cnt_d;
  logic            accept;
  group_t          grp;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // resolve pending bytes plus the new one, at most three units
  always_comb begin
    logic [3:0][7:0] bytes;
    logic [1:0]      n;
    logic [1:0]      head;
    logic [1:0]      avail;
    logic            fin;
    logic            stop;
    logic [7:0]      b0, b1, b2;
    logic [15:0]     unit;
    logic [1:0]      used;
    logic            hold;

    fin   = in_item_i.final_byte;
    bytes = '0;
    case (pend_cnt_q)
      2'd0: begin
        bytes[0] = in_item_i.data_byte;
      end
      2'd1: begin
        bytes[0] = pend_q[0];
        bytes[1] = in_item_i.data_byte;
      end
      default: begin
        bytes[0] = pend_q[0];
        bytes[1] = pend_q[1];
        bytes[2] = in_item_i.data_byte;
      end
    endcase
    n    = (pend_cnt_q >= 2'd2) ? 2'd3 : pend_cnt_q + 2'd1;
    head = '0;
    stop = 1'b0;
    grp  = '0;

    for (int k = 0; k < MaxUnits; k++) begin
      avail = n - head;
      b0    = bytes[head];
      b1    = (avail >= 2'd2) ? bytes[head + 2'd1] : 8'h00;
      b2    = (avail >= 2'd3) ? bytes[head + 2'd2] : 8'h00;
      unit  = {8'h00, b0};
      used  = 2'd1;
      hold  = 1'b0;
      if (!b0[7]) begin
        unit = {8'h00, b0};
      end else if (b0[7:5] == Lead3Code) begin
        if (!fin && avail < 2'd3 && !(avail >= 2'd2 && !is_cont(b1))) begin
          hold = 1'b1;
        end else if (avail >= 2'd3 && is_cont(b1) && is_cont(b2)) begin
          unit = {b0[3:0], b1[5:0], b2[5:0]};
          used = 2'd3;
        end
      end else if (b0[7:5] == Lead2Code) begin
        if (!fin && avail < 2'd2) begin
          hold = 1'b1;
        end else if (avail >= 2'd2 && is_cont(b1)) begin
          unit = {5'b00000, b0[4:0], b1[5:0]};
          used = 2'd2;
        end
      end
      if (!stop && head < n) begin
        if (hold) begin
          stop = 1'b1;
        end else begin
          grp.units[grp.cnt] = unit;
          grp.cnt            = grp.cnt + 2'd1;
          head               = head + used;
        end
      end
    end
    grp.done = fin;

    // what stays undecided
    if (fin) begin
      pend_cnt_d = '0;
    end else begin
      pend_cnt_d = n - head;
    end
    pend_d[0] = bytes[head];
    pend_d[1] = bytes[head + 2'd1];
  end

  assign push_o  = accept && (grp.cnt != 2'd0);
  assign group_o = grp;

  // pending bytes and their count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_cnt_q <= '0;
    end else if (accept) begin
      pend_cnt_q <= pend_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_q <= pend_d;
    end
  end

  a_pend_le2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_cnt_q != 2'd3)
    else $error("pending count beyond buffer");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_item_i.final_byte |=> pend_cnt_q == 2'd0)
    else $error("final item left bytes pending");

  a_final_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_item_i.final_byte |-> push_o)
    else $error("final item released no unit");

endmodule

// ----- rtl/core/u8dec_queue.sv -----
// u8dec_queue: short fifo of unit groups between front and back
// uses u8dec_pkg
`timescale 1ns / 1ps

module u8dec_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  u8dec_pkg::group_t group_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              empty_o,
  output u8dec_pkg::group_t head_o
);
  import u8dec_pkg::*;

  group_t           mem_q [QDepth];
  logic [QAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QAw:0]     count_q;

  assign full_o  = (count_q == (QAw+1)'(QDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // group storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= group_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

  a_group_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> group_i.cnt != 2'd0)
    else $error("empty group queued");

endmodule

// ----- rtl/core/u8dec_back.sv -----
// u8dec_back: sends the units of the head group one per item
// uses u8dec_pkg
`timescale 1ns / 1ps

module u8dec_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  u8dec_pkg::group_t    head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output u8dec_pkg::out_item_t out_item_o
);
  import u8dec_pkg::*;

  logic [1:0] idx_q;
  logic       last;
  logic       accept;

  assign out_valid_o = !empty_i;
  assign accept      = out_valid_o && !out_stall_i;
  assign last        = (idx_q == head_i.cnt - 2'd1);
  assign pop_o       = accept && last;

  // select the current unit of the head group
  assign out_item_o.code_unit   = head_i.units[idx_q];
  assign out_item_o.string_done = head_i.done && last;

  // unit index within the head group
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (accept) begin
      idx_q <= last ? 2'd0 : idx_q + 2'd1;
    end
  end

  a_idx_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> idx_q < head_i.cnt)
    else $error("unit index past group");

  a_idle_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> idx_q == 2'd0)
    else $error("index left mid group");

endmodule

// ----- rtl/core/utf8_to_ucs2_lenient_decoder.sv -----
// utf8_to_ucs2_lenient_decoder: top level, front decoder, group queue, back serializer
// uses u8dec_pkg, u8dec_front, u8dec_queue, u8dec_back
//
//   channel | direction | payload     | handshake
//   --------+-----------+-------------+---------------------------
//   in      | input     | in_item_t   | in_valid_i / in_stall_o
//   out     | output    | out_item_t  | out_valid_o / out_stall_i
//
// one byte is taken per cycle while the four-group queue has room
// the units a byte releases are registered in the group queue and offered from its head
// the output side sends one unit per cycle while out_stall_i is low, so a byte
// releasing k units sends them in turn; the queue absorbs such bursts
// reset clears pending bytes, queue pointers and the unit index
`timescale 1ns / 1ps

module utf8_to_ucs2_lenient_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  u8dec_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output u8dec_pkg::out_item_t out_item_o
);
  import u8dec_pkg::*;

  logic   push, pop, full, empty;
  group_t grp, head;

  u8dec_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (full),
    .push_o     (push),
    .group_o    (grp)
  );

  u8dec_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .group_i (grp),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  u8dec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- sim/testbench.sv -----
// testbench: directed and random byte strings through utf8_to_ucs2_lenient_decoder
// predicts the code units of every accepted byte and checks them in order
// depends on u8dec_pkg and the decoder rtl
`timescale 1ns / 1ps

module testbench;
  import u8dec_pkg::*;

  // byte class tags
  localparam logic [2:0] LeadTriple = 3'b111;
  localparam logic [2:0] LeadPair   = 3'b110;
  localparam logic [1:0] TailTag    = 2'b10;

  localparam int IdlePct     = 11;
  localparam int HoldCycles  = 80;
  localparam int HoldAt      = 120;
  localparam int CalmFrom    = 260;
  localparam int CalmTo      = 340;
  localparam int DrainAt     = 220;
  localparam int TargetBytes = 400;
  localparam int SettleCycles = 20;

  typedef struct {
    in_item_t item;
    bit       wait_drain;
  } byte_slot_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  // bytes waiting to be sent and code units waiting to come back
  byte_slot_t byte_q [$];
  out_item_t  unit_q [$];

  // decoder state as predicted
  logic [7:0] held_bytes [2];
  int         held_cnt;

  int        bytes_taken;
  int        units_seen;
  int        strings_done;
  int        fail_count;
  bit        in_taken;
  int        hold_left;
  bit        hold_done;
  out_item_t want_unit;

  utf8_to_ucs2_lenient_decoder DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always #6 clk_i = ~clk_i;

  // predict the units one byte releases and update the held bytes
  task automatic decode_byte(input in_item_t it);
    logic [7:0]  win [3];
    logic [7:0]  b0, b1, b2;
    logic [15:0] unit;
    out_item_t   res;
    int          n, head, avail, used;
    bit          stop;
    n = held_cnt;
    for (int i = 0; i < n; i++) win[i] = held_bytes[i];
    win[n] = it.data_byte;
    n++;
    head = 0;
    stop = 1'b0;
    while (head < n && !stop) begin
      avail = n - head;
      b0 = win[head];
      b1 = (avail >= 2) ? win[head + 1] : 8'h00;
      b2 = (avail >= 3) ? win[head + 2] : 8'h00;
      unit = {8'h00, b0};
      used = 1;
      if (b0[7:5] == LeadTriple) begin
        // wait for the rest of the sequence unless the next byte already breaks it or the byte is final
        if (!it.final_byte && avail < 3 && !(avail >= 2 && b1[7:6] != TailTag)) begin
          stop = 1'b1;
        end else if (avail >= 3 && b1[7:6] == TailTag && b2[7:6] == TailTag) begin
          unit = {b0[3:0], b1[5:0], b2[5:0]};
          used = 3;
        end
      end else if (b0[7:5] == LeadPair) begin
        if (!it.final_byte && avail < 2) begin
          stop = 1'b1;
        end else if (avail >= 2 && b1[7:6] == TailTag) begin
          unit = {5'b00000, b0[4:0], b1[5:0]};
          used = 2;
        end
      end
      if (!stop) begin
        res.code_unit   = unit;
        res.string_done = it.final_byte && (head + used >= n);
        unit_q.push_back(res);
        head += used;
      end
    end
    if (it.final_byte) begin
      held_cnt = 0;
    end else begin
      held_cnt = n - head;
      for (int i = 0; i < held_cnt; i++) held_bytes[i] = win[head + i];
    end
  endtask

  task automatic add_byte(input logic [7:0] b, input bit fin, input bit drain);
    byte_slot_t slot;
    slot.item.data_byte  = b;
    slot.item.final_byte = fin;
    slot.wait_drain      = drain;
    byte_q.push_back(slot);
  endtask

  // whole string of up to three bytes, first byte in the top slot used
  task automatic add_seq(input logic [23:0] s, input int len);
    for (int k = 0; k < len; k++) add_byte(s[8 * (len - 1 - k) +: 8], k == len - 1, 1'b0);
  endtask

  // sender: offer the next byte or idle
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        in_taken = 1'b0;
        if (byte_q.size() > 0 && !(byte_q[0].wait_drain && unit_q.size() > 0) &&
            ((bytes_taken >= CalmFrom && bytes_taken < CalmTo) ||
             (bytes_taken >= HoldAt && bytes_taken < HoldAt + 40) ||
             $urandom_range(99) >= IdlePct)) begin
          in_valid_i <= 1'b1;
          in_item_i  <= byte_q[0].item;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (!hold_done && bytes_taken >= HoldAt) begin
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !(bytes_taken >= CalmFrom && bytes_taken < CalmTo) &&
                       ($urandom_range(99) < IdlePct);
      end
    end
  end

  // monitor: predict on accepted bytes, check accepted units
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        decode_byte(in_item_i);
        if (in_item_i.final_byte) strings_done++;
        byte_q.delete(0);
        bytes_taken++;
        in_taken = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (unit_q.size() == 0) begin
          $error("code unit %h with nothing expected", out_item_o.code_unit);
          fail_count++;
        end else begin
          want_unit = unit_q.pop_front();
          if (out_item_o.code_unit !== want_unit.code_unit) begin
            $error("code_unit: expected %h, got %h", want_unit.code_unit,
                   out_item_o.code_unit);
            fail_count++;
          end
          if (out_item_o.string_done !== want_unit.string_done) begin
            $error("string_done: expected %b, got %b", want_unit.string_done,
                   out_item_o.string_done);
            fail_count++;
          end
          units_seen++;
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    logic [7:0]  str [$];
    logic [31:0] rnd;
    logic [7:0]  nb;
    int          kind;
    bit          drained;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_stall_i = 1'b0;
    held_cnt    = 0;
    held_bytes[0] = 8'h00;
    held_bytes[1] = 8'h00;
    bytes_taken = 0;
    units_seen  = 0;
    strings_done = 0;
    fail_count  = 0;
    in_taken    = 1'b0;
    hold_left   = 0;
    hold_done   = 1'b0;
    drained     = 1'b0;

    // directed strings: ascii extremes, both sequence lengths, early and late decisions
    add_seq(24'h000041, 1);
    add_seq(24'h00017F, 2);
    add_seq(24'h00C3A9, 2);
    add_seq(24'hE282AC, 3);
    add_seq(24'hFFBF80, 3);
    add_seq(24'h00E041, 2);
    add_byte(8'h80, 1'b0, 1'b0);
    add_seq(24'h00C020, 2);
    add_seq(24'h00E282, 2);
    add_seq(24'h0000DF, 1);
    add_seq(24'h009FF8, 2);
    add_seq(24'hE5C3A9, 3);

    // random strings, mostly well formed, some truncated or noise
    while (byte_q.size() < TargetBytes) begin
      str.delete();
      repeat ($urandom_range(6, 1)) begin
        kind = $urandom_range(99);
        rnd  = $urandom;
        if (kind < 25) begin
          nb = 8'($urandom_range(127, 1));
          str.push_back(nb);
        end else if (kind < 50) begin
          str.push_back({LeadPair, rnd[4:0]});
          str.push_back({TailTag, rnd[10:5]});
        end else if (kind < 78) begin
          str.push_back({LeadTriple, rnd[4:0]});
          str.push_back({TailTag, rnd[10:5]});
          str.push_back({TailTag, rnd[16:11]});
        end else if (kind < 88) begin
          // broken triple: lead and one tail only
          str.push_back({LeadTriple, rnd[4:0]});
          str.push_back({TailTag, rnd[10:5]});
        end else begin
          nb = 8'($urandom_range(255, 1));
          str.push_back(nb);
        end
      end
      for (int i = 0; i < str.size(); i++) begin
        add_byte(str[i], i == str.size() - 1,
                 i == 0 && !drained && byte_q.size() >= DrainAt);
      end
      if (!drained && byte_q.size() >= DrainAt) drained = 1'b1;
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (byte_q.size() > 0 || unit_q.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (unit_q.size() > 0) begin
      $error("%0d code units never arrived", unit_q.size());
      fail_count++;
    end
    $display("sent %0d bytes in %0d strings, checked %0d code units, %0d mismatches",
             bytes_taken, strings_done, units_seen, fail_count);
    $display("covered ascii, two and three byte sequences, stray and truncated bytes");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

endmodule
